[rtl/tcf_pkg.sv]
// Shared types, constants and arithmetic helpers of the tilt complementary filter.
`timescale 1ns / 1ps
`default_nettype none
package tcf_pkg;

	localparam int CordicStepsDefault = 16;
	localparam int AtanEntries        = 24;

	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 16;

	localparam logic [CfgAddrW-1:0] CfgGyroBias   = 3'd0;
	localparam logic [CfgAddrW-1:0] CfgAccelOfs   = 3'd1;
	localparam logic [CfgAddrW-1:0] CfgGyroGain   = 3'd2;
	localparam logic [CfgAddrW-1:0] CfgBlendAlpha = 3'd3;
	localparam logic [CfgAddrW-1:0] CfgTiltLimit  = 3'd4;

	localparam logic signed [10:0] GyroBiasRst   = 11'sd55;
	localparam logic signed [12:0] AccelOfsRst   = 13'sd717;
	localparam logic [15:0]        GyroGainRst   = 16'd10240;
	localparam logic [15:0]        BlendAlphaRst = 16'd655;
	localparam logic [15:0]        TiltLimitRst  = 16'd12800;

	// +-180 degrees in 1/256 degree
	localparam logic signed [23:0] AngMax = 24'sd46080;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ITER,
		ST_GYRO,
		ST_BLEND,
		ST_DONE
	} tcf_state_t;

	typedef struct packed {
		logic       load;
		logic       iter;
		logic [4:0] idx;
		logic       gyro;
		logic       blend;
		logic       commit;
	} tcf_cmd_t;

	// atan(2^-i) in 2^-16 degree
	function automatic logic [21:0] atan_lut(input logic [4:0] i);
		logic [21:0] r;
		case (i)
			5'd0:    r = 22'd2949120;
			5'd1:    r = 22'd1740967;
			5'd2:    r = 22'd919879;
			5'd3:    r = 22'd466945;
			5'd4:    r = 22'd234379;
			5'd5:    r = 22'd117304;
			5'd6:    r = 22'd58666;
			5'd7:    r = 22'd29335;
			5'd8:    r = 22'd14668;
			5'd9:    r = 22'd7334;
			5'd10:   r = 22'd3667;
			5'd11:   r = 22'd1833;
			5'd12:   r = 22'd917;
			5'd13:   r = 22'd458;
			5'd14:   r = 22'd229;
			5'd15:   r = 22'd115;
			5'd16:   r = 22'd57;
			5'd17:   r = 22'd29;
			5'd18:   r = 22'd14;
			5'd19:   r = 22'd7;
			5'd20:   r = 22'd4;
			5'd21:   r = 22'd2;
			5'd22:   r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

	// Clamp an angle to +-180 degrees
	function automatic logic signed [16:0] sat_ang(input logic signed [23:0] v);
		logic signed [16:0] r;
		if (v > AngMax) begin
			r = AngMax[16:0];
		end else if (v < -AngMax) begin
			r = 17'(-AngMax);
		end else begin
			r = v[16:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/tcf_ctrl.sv]
// Sequencer of the tilt filter: handshakes, CORDIC iteration count, result hold.
`timescale 1ns / 1ps
`default_nettype none
module tcf_ctrl import tcf_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDefault
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	output tcf_cmd_t      cmd
);

	localparam int NumIter = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;

	tcf_state_t state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.idx = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_ITER;
				end
			end
			ST_ITER: begin
				cmd.iter = 1'b1;
				cnt_d    = cnt_q + 5'd1;
				if (cnt_q == 5'(NumIter - 1)) begin
					state_d = ST_GYRO;
				end
			end
			ST_GYRO: begin
				cmd.gyro = 1'b1;
				state_d  = ST_BLEND;
			end
			ST_BLEND: begin
				cmd.blend = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free or being drained
				if (!out_valid_q || m_tready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		if (cmd.commit) begin
			out_valid_d = 1'b1;
		end else if (m_tready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || m_tready))
		else $error("result committed over an undelivered beat");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_ITER && cnt_q == 5'd0))
		else $error("accepted beat did not start CORDIC");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER) |-> (cnt_q < 5'(NumIter)))
		else $error("CORDIC iteration count overrun");

endmodule
`default_nettype wire

[rtl/tcf_dp.sv]
// Datapath of the tilt filter: config registers, CORDIC, gyro and blend arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module tcf_dp import tcf_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CfgAddrW-1:0]    cfg_addr,
	input  wire logic [CfgDataW-1:0]    cfg_wdata,
	input  wire tcf_cmd_t               cmd,
	input  wire logic signed [15:0]     accel_x,
	input  wire logic signed [15:0]     accel_z,
	input  wire logic signed [15:0]     gyro_y,
	output logic signed [16:0]          tilt_angle,
	output logic signed [16:0]          accel_angle,
	output logic                        tilt_fault
);

	localparam logic signed [25:0] Z180 = 26'sd11796480;

	logic signed [10:0] gyro_bias_q;
	logic signed [12:0] accel_ofs_q;
	logic [15:0]        gyro_gain_q;
	logic [15:0]        blend_alpha_q;
	logic [15:0]        tilt_limit_q;
	logic signed [17:0] est_q;

	logic signed [15:0] g_q;
	logic signed [25:0] x_q, y_q, z_q;
	logic               zero_q;
	logic signed [32:0] step_prod_q;
	logic signed [16:0] gyro_ang_q, acc_q;
	logic signed [35:0] blend_prod_q;
	logic signed [16:0] out_tilt_q, out_acc_q;
	logic               out_fault_q;

	// load
	logic signed [16:0] g_sum;
	logic signed [15:0] g_sat;
	logic signed [25:0] x_pre, y_pre;
	// iterate
	logic signed [25:0] xs, ys, atan_v;
	// gyro stage
	logic signed [33:0] step_rnd;
	logic signed [17:0] step_v;
	logic signed [18:0] gsum;
	logic signed [25:0] z_eff, z_rnd;
	logic signed [17:0] zs;
	logic signed [18:0] zneg;
	logic signed [19:0] acc_sum;
	// blend / commit
	logic signed [18:0] diff;
	logic signed [36:0] b_rnd;
	logic signed [20:0] blend_v;
	logic signed [21:0] a_sum;
	logic signed [16:0] a_v;
	logic [16:0]        a_mag;

	always_comb begin
		g_sum = {gyro_y[15], gyro_y} + {{6{gyro_bias_q[10]}}, gyro_bias_q};
		if (g_sum > 17'sd32767) begin
			g_sat = 16'sd32767;
		end else if (g_sum < -17'sd32768) begin
			g_sat = -16'sd32768;
		end else begin
			g_sat = g_sum[15:0];
		end
		x_pre = {{2{accel_z[15]}}, accel_z, 8'd0};
		y_pre = {{2{accel_x[15]}}, accel_x, 8'd0};

		xs     = x_q >>> cmd.idx;
		ys     = y_q >>> cmd.idx;
		atan_v = {4'd0, atan_lut(cmd.idx)};

		step_rnd = {step_prod_q[32], step_prod_q} + 34'sd32768;
		step_v   = step_rnd[33:16];
		gsum     = {est_q[17], est_q} + {step_v[17], step_v};
		z_eff    = zero_q ? 26'sd0 : z_q;
		z_rnd    = z_eff + 26'sd128;
		zs       = z_rnd[25:8];
		zneg     = -{zs[17], zs};
		acc_sum  = {zneg[18], zneg} + {{7{accel_ofs_q[12]}}, accel_ofs_q};

		diff    = {{2{acc_q[16]}}, acc_q} - {{2{gyro_ang_q[16]}}, gyro_ang_q};
		b_rnd   = {blend_prod_q[35], blend_prod_q} + 37'sd32768;
		blend_v = b_rnd[36:16];
		a_sum   = {{5{gyro_ang_q[16]}}, gyro_ang_q} + {blend_v[20], blend_v};
		a_v     = sat_ang({{2{a_sum[21]}}, a_sum});
		a_mag   = a_v[16] ? 17'(-a_v) : 17'(a_v);
	end

	// configuration and stored angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_bias_q   <= GyroBiasRst;
			accel_ofs_q   <= AccelOfsRst;
			gyro_gain_q   <= GyroGainRst;
			blend_alpha_q <= BlendAlphaRst;
			tilt_limit_q  <= TiltLimitRst;
			est_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CfgGyroBias:   gyro_bias_q   <= cfg_wdata[10:0];
					CfgAccelOfs:   accel_ofs_q   <= cfg_wdata[12:0];
					CfgGyroGain:   gyro_gain_q   <= cfg_wdata;
					CfgBlendAlpha: blend_alpha_q <= cfg_wdata;
					CfgTiltLimit:  tilt_limit_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				est_q <= {a_v[16], a_v};
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			g_q    <= g_sat;
			zero_q <= (accel_x == 16'sd0) && (accel_z == 16'sd0);
			if (accel_z[15]) begin
				x_q <= -x_pre;
				y_q <= -y_pre;
				z_q <= accel_x[15] ? -Z180 : Z180;
			end else begin
				x_q <= x_pre;
				y_q <= y_pre;
				z_q <= '0;
			end
		end
		if (cmd.iter) begin
			if (!y_q[25]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end
			step_prod_q <= g_q * $signed({1'b0, gyro_gain_q});
		end
		if (cmd.gyro) begin
			gyro_ang_q <= sat_ang({{5{gsum[18]}}, gsum});
			acc_q      <= sat_ang({{4{acc_sum[19]}}, acc_sum});
		end
		if (cmd.blend) begin
			blend_prod_q <= $signed({1'b0, blend_alpha_q}) * diff;
		end
		if (cmd.commit) begin
			out_tilt_q  <= a_v;
			out_acc_q   <= acc_q;
			out_fault_q <= a_mag > {1'b0, tilt_limit_q};
		end
	end

	assign tilt_angle  = out_tilt_q;
	assign accel_angle = out_acc_q;
	assign tilt_fault  = out_fault_q;

endmodule
`default_nettype wire

[rtl/tilt_complementary_filter.sv]
// Top level of the tilt complementary filter: stream ports, config port, sequencer and datapath.
//
// Usage:
//   Slave stream takes one inertial sample per beat; master stream returns one
//   filtered result per sample. A beat moves on a rising edge with tvalid and
//   tready both high. Configuration is a write-only port: cfg_we with cfg_addr
//   selecting gyro_bias (0), accel_angle_offset (1), gyro_gain (2),
//   blend_alpha (3) or tilt_limit (4); other addresses are dropped. Write it
//   only while no sample is in flight.
// Sequence:
//   From its accept edge a sample runs the CORDIC vectoring iterations (CORDIC_STEPS,
//   capped at 24) in the shared shift-add unit, then the gyro, blend and commit
//   steps; the commit raises m_tvalid. s_tready is high only while the sequencer
//   is idle, so one sample is at work at a time and a new sample is taken only
//   after the last one commits.
// Reset:
//   arst_n clears the stored angle to zero, loads the register defaults and
//   empties the output register.
// Stall:
//   The result waits in the output register; a finished sample whose output
//   register is still full holds in the commit step until m_tready frees it.
`timescale 1ns / 1ps
`default_nettype none
module tilt_complementary_filter import tcf_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgAddrW-1:0] cfg_addr,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [47:0]         s_tdata,  // accel_x[15:0], accel_z[31:16], gyro_y[47:32]
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [39:0]              m_tdata   // tilt_angle[16:0], accel_angle[33:17],
	                                           // tilt_fault[34], zero[39:35]
);

	tcf_cmd_t           cmd;
	logic signed [16:0] tilt_angle, accel_angle;
	logic               tilt_fault;

	// sequencer: handshakes and step order
	tcf_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// arithmetic, registers and the held result
	tcf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.accel_x     (s_tdata[15:0]),
		.accel_z     (s_tdata[31:16]),
		.gyro_y      (s_tdata[47:32]),
		.tilt_angle  (tilt_angle),
		.accel_angle (accel_angle),
		.tilt_fault  (tilt_fault)
	);

	assign m_tdata = {5'd0, tilt_fault, accel_angle, tilt_angle};

endmodule
`default_nettype wire
